// ----- hdl/wnm_pkg.sv -----
// shared types and constants for the wildcard name matcher
`timescale 1ns / 1ps

package wnm_pkg;

   localparam int PATTERN_SLOTS = 14;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ANY   = 8'h3F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      VERDICT_NO_MATCH  = 2'd0,
      VERDICT_MATCH     = 2'd1,
      VERDICT_MALFORMED = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      REG_PATTERN_LOW    = 2'd0,
      REG_PATTERN_HIGH   = 2'd1,
      REG_PATTERN_LENGTH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  position;
      logic        star_waiting;
      logic        decided;
      verdict_type early_verdict;
   } match_state_type;

endpackage

// ----- hdl/wildcard_name_matcher_top.sv -----
// top level of the streamed wildcard file-name matcher
`timescale 1ns / 1ps

//  channel | direction | ports                                  | transfer when
//  --------+-----------+----------------------------------------+------------------------
//  req     | in        | req_valid req_stall req_name_char       | req_valid & !req_stall
//          |           | req_last_char                          |
//  rsp     | out       | rsp_valid rsp_stall rsp_verdict         | rsp_valid & !rsp_stall
//  csr     | in        | psel penable pwrite paddr pwdata prdata | psel&penable&pwrite&pready
//
//  one character per cycle while req_stall is low: a transfer lands in the input register,
//  then the match step runs against the pattern registers and updates the per-name state
//  a verdict is written to the result register at the marked last character, which passes
//  the input register and then the match step; the result register drives rsp_valid
//  reset clears the pattern registers, the per-name state and both valid flags
//  req_stall rises only while the input register holds an item and the result register
//  holds a verdict that is being stalled

module wildcard_name_matcher_top #(
   parameter int MAX_PATTERN = 14
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_char,
   input  logic        req_last_char,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   // pattern registers
   logic [63:0] pat_low_ff;
   logic [47:0] pat_high_ff;
   logic [3:0]  pat_len_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_last_ff;

   // per-name state
   wnm_pkg::match_state_type state_ff, state_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   wnm_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;

   logic                 out_free;
   logic                 step;
   logic                 csr_write;
   wnm_pkg::reg_index_type csr_index;

   logic [7:0] pat_char [16];
   logic [3:0] eff_len;
   logic [7:0] cur_char;
   logic [7:0] next_char;
   logic [3:0] close_pos;
   logic       close_seen;
   logic       set_hit;

   assign pready    = 1'b1;
   assign csr_index = wnm_pkg::reg_index_type'(paddr[4:3]);
   assign csr_write = psel & penable & pwrite;

   // register reads
   always_comb begin
      unique case (csr_index)
         wnm_pkg::REG_PATTERN_LOW:    prdata = pat_low_ff;
         wnm_pkg::REG_PATTERN_HIGH:   prdata = {16'd0, pat_high_ff};
         wnm_pkg::REG_PATTERN_LENGTH: prdata = {60'd0, pat_len_ff};
         default:                     prdata = 64'd0;
      endcase
   end

   // the step runs when the result register can take whatever it produces
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // pattern characters by index, slots past the register width read as zero
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (i < 8) begin
            pat_char[i] = pat_low_ff[8*i +: 8];
         end else if (i < wnm_pkg::PATTERN_SLOTS) begin
            pat_char[i] = pat_high_ff[8*(i-8) +: 8];
         end else begin
            pat_char[i] = 8'd0;
         end
      end
   end

   // length above the limit is clamped
   assign eff_len   = (pat_len_ff > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pat_len_ff;
   assign cur_char  = pat_char[state_ff.position];
   assign next_char = pat_char[state_ff.position + 4'd1];

   // first closing bracket after the current position, inside the pattern
   always_comb begin
      close_pos  = eff_len;
      close_seen = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (!close_seen && (4'(i) > state_ff.position) && (4'(i) < eff_len)
             && (pat_char[i] == wnm_pkg::CH_CLOSE)) begin
            close_pos  = 4'(i);
            close_seen = 1'b1;
         end
      end
   end

   // set membership over the characters between the brackets
   always_comb begin
      set_hit = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if ((4'(i) > state_ff.position) && (4'(i) < close_pos)
             && (pat_char[i] == in_char_ff)) begin
            set_hit = 1'b1;
         end
      end
   end

   // match step and verdict
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      if (step) begin
         priority if (state_ff.decided) begin
            // verdict already fixed, ignore the rest of the name
         end else if (state_ff.position >= eff_len) begin
            // pattern used up
            state_in.decided       = 1'b1;
            state_in.early_verdict = wnm_pkg::VERDICT_NO_MATCH;
         end else if (state_ff.star_waiting) begin
            if (in_char_ff == cur_char) begin
               state_in.star_waiting = 1'b0;
               state_in.position     = state_ff.position + 4'd1;
            end
         end else if (cur_char == wnm_pkg::CH_STAR) begin
            priority if (state_ff.position + 4'd1 == eff_len) begin
               // trailing star takes the rest of the name
               state_in.decided       = 1'b1;
               state_in.early_verdict = wnm_pkg::VERDICT_MATCH;
            end else if (in_char_ff == next_char) begin
               state_in.position = state_ff.position + 4'd2;
            end else begin
               state_in.star_waiting = 1'b1;
               state_in.position     = state_ff.position + 4'd1;
            end
         end else if (cur_char == wnm_pkg::CH_ANY) begin
            state_in.position = state_ff.position + 4'd1;
         end else if (cur_char == wnm_pkg::CH_OPEN) begin
            priority if (!close_seen) begin
               // unclosed bracket
               state_in.decided       = 1'b1;
               state_in.early_verdict = wnm_pkg::VERDICT_MALFORMED;
            end else if (!set_hit) begin
               state_in.decided       = 1'b1;
               state_in.early_verdict = wnm_pkg::VERDICT_NO_MATCH;
            end else begin
               state_in.position = close_pos + 4'd1;
            end
         end else begin
            if (in_char_ff != cur_char) begin
               state_in.decided       = 1'b1;
               state_in.early_verdict = wnm_pkg::VERDICT_NO_MATCH;
            end else begin
               state_in.position = state_ff.position + 4'd1;
            end
         end

         if (in_last_ff) begin
            rsp_valid_in = 1'b1;
            priority if (state_in.decided) begin
               rsp_verdict_in = state_in.early_verdict;
            end else if (state_in.star_waiting) begin
               rsp_verdict_in = wnm_pkg::VERDICT_NO_MATCH;
            end else if (state_in.position == eff_len) begin
               rsp_verdict_in = wnm_pkg::VERDICT_MATCH;
            end else begin
               rsp_verdict_in = wnm_pkg::VERDICT_NO_MATCH;
            end
            // back to the start for the next name
            state_in.position      = 4'd0;
            state_in.star_waiting  = 1'b0;
            state_in.decided       = 1'b0;
            state_in.early_verdict = wnm_pkg::VERDICT_NO_MATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= 64'd0;
         pat_high_ff  <= 48'd0;
         pat_len_ff   <= 4'd0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{position: 4'd0, star_waiting: 1'b0, decided: 1'b0,
                           early_verdict: wnm_pkg::VERDICT_NO_MATCH};
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               wnm_pkg::REG_PATTERN_LOW:    pat_low_ff  <= pwdata;
               wnm_pkg::REG_PATTERN_HIGH:   pat_high_ff <= pwdata[47:0];
               wnm_pkg::REG_PATTERN_LENGTH: pat_len_ff  <= pwdata[3:0];
               default: ;
            endcase
         end
         // input register refills whenever it is empty or being drained
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_char_ff <= req_name_char;
         in_last_ff <= req_last_char;
      end
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule
